@@ design/pdgf_pkg.sv @@
package pdgf_pkg;

  localparam int NUM_VALUES   = 8;
  localparam int EARLY_LEVELS = 11;
  localparam int MAX_FILL     = 63;
  localparam int STEP_BITS    = 14;
  localparam int SLOT_BITS    = 4;
  localparam int FILL_BITS    = 6;
  localparam int LANE_BITS    = 3;
  localparam int DVD_BITS     = 57;
  localparam int DVS_BITS     = 33;

  localparam logic [SLOT_BITS-1:0] LAST_EARLY = SLOT_BITS'(EARLY_LEVELS - 1);
  localparam logic [SLOT_BITS-1:0] HELD_SLOT  = SLOT_BITS'(EARLY_LEVELS);

  typedef enum logic [0:0] {
    REG_FILL_MODE  = 1'b0,
    REG_LEVEL_STEP = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] in_pressure;
    logic signed [31:0] in_depth;
    logic signed [31:0] in_prop_one;
    logic signed [31:0] in_prop_two;
    logic signed [31:0] in_prop_three;
    logic signed [31:0] in_prop_four;
    logic signed [31:0] in_prop_five;
    logic signed [31:0] in_prop_six;
    logic               in_station_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pressure;
    logic signed [31:0] out_depth;
    logic signed [31:0] out_prop_one;
    logic signed [31:0] out_prop_two;
    logic signed [31:0] out_prop_three;
    logic signed [31:0] out_prop_four;
    logic signed [31:0] out_prop_five;
    logic signed [31:0] out_prop_six;
    logic               out_run_last;
    logic               out_station_end;
  } out_item_t;

  typedef logic [NUM_VALUES-1:0][31:0] vals_t;

  typedef struct packed {
    logic [DVD_BITS-1:0] dividend;
    logic [DVS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DVD_BITS-1:0] quotient;
    logic [DVS_BITS-1:0] remainder;
  } div_res_t;

endpackage

@@ design/pdgf_div.sv @@
module pdgf_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pdgf_pkg::div_req_t  req,
  output logic                done,
  output pdgf_pkg::div_res_t  res
);
  import pdgf_pkg::*;

  localparam int CNT_BITS = $clog2(DVD_BITS);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0] dvd;
  logic [DVS_BITS-1:0] dvs;
  logic [DVD_BITS-1:0] quo;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS:0]   trial;
  logic                fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, dvd[DVD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign res   = '{quotient: quo, remainder: rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DVD_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      quo <= {quo[DVD_BITS-2:0], fits};
      rem <= fits ? DVS_BITS'(trial - {1'b0, dvs}) : trial[DVS_BITS-1:0];
    end
  end

endmodule

@@ design/profile_decimate_or_gap_fill_unit.sv @@
// channel  | direction | handshake                 | payload
// level    | in        | level_valid / level_stall | level_data  (pdgf_pkg::in_item_t)
// result   | out       | result_valid/result_stall | result_data (pdgf_pkg::out_item_t)
// cfg      | in        | cfg_write                 | cfg_index, cfg_data
//
// one level request is worked on at a time; level_stall is high until its last result
// has been loaded into the output register
// decimate: the first eleven levels are buffered; the eleventh starts the stride division
// and the buffered levels then go out at that stride; later levels pass through or are dropped
// fill: a gap takes one division per value except depth, then the inserted levels go out
// rst is synchronous and clears control only; the level memory needs no clearing pass
// a stall on the result side holds the sequencer in its emitting state
module profile_decimate_or_gap_fill_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                level_valid,
  output logic                                level_stall,
  input  pdgf_pkg::in_item_t                  level_data,
  output logic                                result_valid,
  input  logic                                result_stall,
  output pdgf_pkg::out_item_t                 result_data,
  input  logic                                cfg_write,
  input  logic [0:0]                          cfg_index,
  input  logic [pdgf_pkg::STEP_BITS-1:0]      cfg_data
);
  import pdgf_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_HWAIT   = 12'b000000000010,
    S_GAP     = 12'b000000000100,
    S_MUL     = 12'b000000001000,
    S_DIVGO   = 12'b000000010000,
    S_DIVW    = 12'b000000100000,
    S_FADV    = 12'b000001000000,
    S_FOUT    = 12'b000010000000,
    S_EMITCUR = 12'b000100000000,
    S_SDW     = 12'b001000000000,
    S_RD      = 12'b010000000000,
    S_EMITM   = 12'b100000000000
  } state_t;

  function automatic vals_t item_vals(in_item_t it);
    vals_t v;
    v[0] = it.in_pressure;
    v[1] = it.in_depth;
    v[2] = it.in_prop_one;
    v[3] = it.in_prop_two;
    v[4] = it.in_prop_three;
    v[5] = it.in_prop_four;
    v[6] = it.in_prop_five;
    v[7] = it.in_prop_six;
    return v;
  endfunction

  function automatic out_item_t make_out(vals_t v, logic last, logic send);
    out_item_t o;
    o.out_pressure    = v[0];
    o.out_depth       = v[1];
    o.out_prop_one    = v[2];
    o.out_prop_two    = v[3];
    o.out_prop_three  = v[4];
    o.out_prop_four   = v[5];
    o.out_prop_five   = v[6];
    o.out_prop_six    = v[7];
    o.out_run_last    = last;
    o.out_station_end = send;
    return o;
  endfunction

  // configuration
  logic                 fill_mode;
  logic [STEP_BITS-1:0] level_step;

  // station control
  state_t               state;
  logic                 station_mode;
  logic                 held_emitted;
  logic [SLOT_BITS-1:0] level_index;
  logic [STEP_BITS-1:0] stride;
  logic [STEP_BITS-1:0] since_emit;

  // current request and decimation pointers
  in_item_t             cur;
  logic [31:0]          p4;
  logic [31:0]          p5;
  logic [SLOT_BITS-1:0] ptr;
  logic [STEP_BITS-1:0] step;
  logic [SLOT_BITS-1:0] limit;
  logic                 tail_en;

  // gap fill datapath
  vals_t                prev;
  logic [DVS_BITS-1:0]  span;
  logic signed [34:0]   x;
  logic [FILL_BITS-1:0] fc;
  logic [LANE_BITS-1:0] lane;
  logic [DVD_BITS-1:0]  prod;
  logic [NUM_VALUES-1:0]               neg;
  logic [NUM_VALUES-1:0][DVS_BITS-1:0] inc_q;
  logic [NUM_VALUES-1:0][DVS_BITS-1:0] inc_r;
  logic [NUM_VALUES-1:0][DVS_BITS-1:0] acc_q;
  logic [NUM_VALUES-1:0][DVS_BITS-1:0] acc_r;

  // level memory: early levels in slots 0..10, held level in slot 11
  vals_t                mem [0:EARLY_LEVELS];
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_wa;
  logic [SLOT_BITS-1:0] rd_addr;
  vals_t                rd_data;

  // output register
  logic                 out_load;
  out_item_t            out_next;

  // divider
  logic                 div_start;
  div_req_t             div_req;
  logic                 div_done;
  div_res_t             div_res;

  logic                 accept;
  logic                 can_load;
  logic                 mode_now;
  logic                 held_now;
  vals_t                cur_vals;
  logic [STEP_BITS:0]   count;
  logic [23:0]          stepq;
  logic [24:0]          gap_thresh;
  logic signed [33:0]   diff;
  logic [32:0]          d45;
  logic [DVS_BITS-1:0]  spacing;
  logic signed [32:0]   dy;
  logic [32:0]          mag;
  logic                 x_below;
  vals_t                fill_vals;
  logic [STEP_BITS:0]   nxt;
  logic                 more;
  logic                 tail;
  logic [STEP_BITS-1:0] se_inc;

  assign accept      = level_valid && !level_stall;
  assign level_stall = (state != S_IDLE);
  assign can_load    = !result_valid || !result_stall;
  assign mode_now    = (level_index == '0) ? fill_mode : station_mode;
  assign held_now    = (level_index == '0) ? 1'b0 : held_emitted;
  assign cur_vals    = item_vals(cur);
  assign count       = (STEP_BITS+1)'(level_index) + 1'b1;
  assign stepq       = {level_step, 10'b0};
  assign gap_thresh  = {(STEP_BITS+1)'(level_step) + 1'b1, 10'b0};
  assign diff        = 34'(signed'(cur.in_depth)) - 34'(signed'(prev[1]));
  assign se_inc      = since_emit + 1'b1;

  // pressure spacing of levels 4 and 5, whole units, at least one
  assign d45     = 33'(signed'(p5)) - 33'(signed'(p4));
  assign spacing = ($signed(d45) >= 33'sd1024) ? DVS_BITS'(d45[32:10]) : DVS_BITS'(1);

  // per-lane difference for the interpolation slope
  assign dy  = 33'(signed'(cur_vals[lane])) - 33'(signed'(prev[lane]));
  assign mag = dy[32] ? 33'(-dy) : 33'(dy);

  assign x_below = x < 35'(signed'(cur.in_depth));

  // interpolated level: y0 +/- running quotient, depth from the running x
  always_comb begin
    for (int j = 0; j < NUM_VALUES; j++) begin
      fill_vals[j] = neg[j] ? prev[j] - acc_q[j][31:0] : prev[j] + acc_q[j][31:0];
    end
    fill_vals[1] = x[31:0];
  end

  // decimation walk: next stride point, or the bottom level as a tail
  assign nxt  = (STEP_BITS+1)'(ptr) + (STEP_BITS+1)'(step);
  assign more = nxt < (STEP_BITS+1)'(limit);
  assign tail = tail_en && (ptr != LAST_EARLY) && !more;

  // memory port: write the request as it comes in, read-first on the held slot
  assign mem_we  = accept && (mode_now || (level_index < SLOT_BITS'(EARLY_LEVELS)));
  assign mem_wa  = mode_now ? HELD_SLOT : level_index;
  assign rd_addr = (state == S_IDLE) ? HELD_SLOT : ptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= item_vals(level_data);
    end
    rd_data <= mem[rd_addr];
  end

  assign div_start = (accept && !mode_now && level_index == LAST_EARLY) || (state == S_DIVGO);
  assign div_req   = (state == S_DIVGO) ? div_req_t'{dividend: prod, divisor: span}
                                        : div_req_t'{dividend: DVD_BITS'(level_step),
                                                     divisor: spacing};

  pdgf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .res   (div_res)
  );

  // what goes into the output register this cycle
  always_comb begin
    out_load = 1'b0;
    out_next = make_out(cur_vals, 1'b1, cur.in_station_end);
    case (state)
      S_FOUT: begin
        out_load = can_load && x_below && (fc != FILL_BITS'(MAX_FILL));
        out_next = make_out(fill_vals, 1'b0, 1'b0);
      end
      S_EMITCUR: begin
        out_load = can_load;
      end
      S_EMITM: begin
        out_load = can_load;
        out_next = make_out(rd_data, !more && !tail, !more && !tail && cur.in_station_end);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_data <= out_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode  <= 1'b0;
      level_step <= STEP_BITS'(10);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILL_MODE:  fill_mode  <= cfg_data[0];
        REG_LEVEL_STEP: level_step <= cfg_data;
        default:        fill_mode  <= fill_mode;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      station_mode <= 1'b0;
      held_emitted <= 1'b0;
      level_index  <= '0;
      stride       <= STEP_BITS'(1);
      since_emit   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur <= level_data;
            if (level_index == '0) begin
              station_mode <= fill_mode;
            end
            if (mode_now) begin
              // fill: held slot was read before this write replaced it
              held_emitted <= !level_data.in_station_end;
              level_index  <= level_data.in_station_end ? '0 : SLOT_BITS'(1);
              state        <= held_now ? S_HWAIT : S_EMITCUR;
            end else if (level_index < SLOT_BITS'(EARLY_LEVELS)) begin
              if (level_index == SLOT_BITS'(4)) begin
                p4 <= level_data.in_pressure;
              end
              if (level_index == SLOT_BITS'(5)) begin
                p5 <= level_data.in_pressure;
              end
              if (level_index == LAST_EARLY) begin
                // buffer full: stride division already started
                level_index <= level_data.in_station_end ? '0 : SLOT_BITS'(EARLY_LEVELS);
                state       <= S_SDW;
              end else if (level_data.in_station_end) begin
                // short station goes out unchanged
                ptr         <= '0;
                step        <= STEP_BITS'(1);
                limit       <= count[SLOT_BITS-1:0];
                tail_en     <= 1'b0;
                level_index <= '0;
                state       <= S_RD;
              end else begin
                level_index <= count[SLOT_BITS-1:0];
              end
            end else begin
              if (se_inc >= stride || level_data.in_station_end) begin
                since_emit <= '0;
                state      <= S_EMITCUR;
              end else begin
                since_emit <= se_inc;
              end
              if (level_data.in_station_end) begin
                level_index <= '0;
              end
            end
          end
        end
        S_HWAIT: begin
          prev  <= rd_data;
          state <= S_GAP;
        end
        S_GAP: begin
          span <= diff[DVS_BITS-1:0];
          x    <= 35'(signed'(prev[1])) + 35'(stepq);
          lane <= '0;
          state <= ($signed(diff) >= $signed(34'(gap_thresh))) ? S_MUL : S_EMITCUR;
        end
        S_MUL: begin
          prod      <= {DVD_BITS'(mag * level_step)} << 10;
          neg[lane] <= dy[32];
          state     <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            // per-step increment of quotient and remainder for this value
            inc_q[lane] <= div_res.quotient[DVS_BITS-1:0];
            inc_r[lane] <= div_res.remainder;
            acc_q[lane] <= '0;
            acc_r[lane] <= span >> 1;
            if (lane == LANE_BITS'(NUM_VALUES - 1)) begin
              fc    <= '0;
              state <= S_FADV;
            end else begin
              lane  <= (lane == '0) ? LANE_BITS'(2) : lane + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_FADV: begin
          for (int j = 0; j < NUM_VALUES; j++) begin
            if ({1'b0, acc_r[j]} + {1'b0, inc_r[j]} >= {1'b0, span}) begin
              acc_r[j] <= DVS_BITS'({1'b0, acc_r[j]} + {1'b0, inc_r[j]} - {1'b0, span});
              acc_q[j] <= acc_q[j] + inc_q[j] + 1'b1;
            end else begin
              acc_r[j] <= acc_r[j] + inc_r[j];
              acc_q[j] <= acc_q[j] + inc_q[j];
            end
          end
          state <= S_FOUT;
        end
        S_FOUT: begin
          if (x_below && (fc != FILL_BITS'(MAX_FILL))) begin
            if (can_load) begin
              x     <= x + 35'(stepq);
              fc    <= fc + 1'b1;
              state <= S_FADV;
            end
          end else begin
            state <= S_EMITCUR;
          end
        end
        S_EMITCUR: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        S_SDW: begin
          if (div_done) begin
            stride  <= (div_res.quotient == '0) ? STEP_BITS'(1)
                                                : div_res.quotient[STEP_BITS-1:0];
            step    <= (div_res.quotient == '0) ? STEP_BITS'(1)
                                                : div_res.quotient[STEP_BITS-1:0];
            ptr     <= '0;
            limit   <= SLOT_BITS'(EARLY_LEVELS);
            tail_en <= cur.in_station_end;
            state   <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EMITM;
        end
        S_EMITM: begin
          if (can_load) begin
            since_emit <= STEP_BITS'(LAST_EARLY - ptr);
            if (more) begin
              ptr   <= nxt[SLOT_BITS-1:0];
              state <= S_RD;
            end else if (tail) begin
              ptr   <= LAST_EARLY;
              state <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    level_index <= SLOT_BITS'(EARLY_LEVELS))
    else $error("level index past buffer");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_SDW || state == S_DIVW))
    else $error("divider finished with nobody waiting");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.out_run_last) |=> (state == S_IDLE))
    else $error("sequencer busy after last result");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOUT && out_load) |-> (fc != FILL_BITS'(MAX_FILL)))
    else $error("too many inserted levels");
`endif

endmodule
